// ===== rtl/core/dds_pkg.sv =====
// Package for the discrete distribution sampler: sizes, fixed-point constants,
// opcode and status codes, and the token that walks the cell chain.
// No dependencies.
`default_nettype none

package dds_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int MAX_WEIGHTS = 1024;
  localparam int FRAC_BITS   = 16;

  localparam int VAL_W  = FRAC_BITS + 1;              // Q1.FRAC_BITS value
  localparam int IDX_W  = 10;                         // outcome_index field width
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);    // entry count, holds TABLE_DEPTH
  localparam int ADDR_W = $clog2(TABLE_DEPTH);        // cell address
  localparam int WCNT_W = $clog2(MAX_WEIGHTS + 1);    // weight position count
  localparam int OP_W   = 2;
  localparam int ST_W   = 3;

  localparam logic [VAL_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_SAMPLE = 2'd2
  } opcode_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 3'd0,
    ST_ZERO  = 3'd1,
    ST_OVER  = 3'd2,
    ST_FULL  = 3'd3,
    ST_MISS  = 3'd4,
    ST_SHORT = 3'd5
  } status_t;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic             valid;
    logic             found;
    logic [IDX_W-1:0] idx;
  } tok_t;

endpackage

`default_nettype wire

// ===== rtl/core/dds_if.sv =====
// Valid/ready channel interfaces for the sampler: input items and result items.
// Depends on dds_pkg.
`default_nettype none

interface dds_in_if
  import dds_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [VAL_W-1:0] weight;
  logic [VAL_W-1:0] uniform;

  modport source (output valid, output opcode, output weight, output uniform, input ready);
  modport sink   (input valid, input opcode, input weight, input uniform, output ready);
endinterface

interface dds_out_if
  import dds_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] outcome_index;
  logic [ST_W-1:0]  status;
  logic [VAL_W-1:0] total;
  logic [CNT_W-1:0] entry_total;

  modport source (output valid, output outcome_index, output status, output total,
                  output entry_total, input ready);
  modport sink   (input valid, input outcome_index, input status, input total,
                  input entry_total, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/dds_cell.sv =====
// One table cell: holds a cumulative sum and its origin position, and passes
// the search token on to the next cell each cycle. Depends on dds_pkg.
`default_nettype none

module dds_cell
  import dds_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             flush,
  input  wire logic             wr_en,
  input  wire logic [VAL_W-1:0] wr_cum,
  input  wire logic [IDX_W-1:0] wr_org,
  input  wire logic [VAL_W-1:0] uni,
  input  wire tok_t             tok_i,
  output      tok_t             tok_o
);

  logic [VAL_W-1:0] cum_r;
  logic [IDX_W-1:0] org_r;
  tok_t             tok_r;
  tok_t             tok_nxt;
  logic             hit;

  // A full draw matches only an entry that reached one exactly.
  assign hit = (cum_r > uni) || ((cum_r == ONE) && (uni == ONE));

  always_comb begin
    tok_nxt = tok_i;
    if (tok_i.valid && !tok_i.found && hit) begin
      tok_nxt.found = 1'b1;
      tok_nxt.idx   = org_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cum_r <= wr_cum;
      org_r <= wr_org;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

`default_nettype wire

// ===== rtl/core/dds_chain.sv =====
// Row of TABLE_DEPTH cells; the search token enters at cell 0 and moves one
// cell per cycle. Depends on dds_pkg and dds_cell.
`default_nettype none

module dds_chain
  import dds_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              flush,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [VAL_W-1:0]  wr_cum,
  input  wire logic [IDX_W-1:0]  wr_org,
  input  wire logic [VAL_W-1:0]  uni,
  output      tok_t              tok_o [TABLE_DEPTH]
);

  tok_t link [TABLE_DEPTH+1];

  assign link[0] = '{valid: start, found: 1'b0, idx: '0};

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    dds_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .flush  (flush),
      .wr_en  (wr_en && (wr_addr == ADDR_W'(k))),
      .wr_cum (wr_cum),
      .wr_org (wr_org),
      .uni    (uni),
      .tok_i  (link[k]),
      .tok_o  (link[k+1])
    );
    assign tok_o[k] = link[k+1];
  end

endmodule

`default_nettype wire

// ===== rtl/core/discrete_distribution_sampler.sv =====
// Discrete distribution sampler, inverse-CDF lookup over a chain of table cells.
// Clear, append and unused opcodes go straight to the result registers and then to the
// output register; a sample first walks the token through the chain (skipped for u = 0 or
// an empty table), one cell per cycle, up to the last stored entry.
// One item in flight: input is taken again once the result moves to the output register.
// Synchronous active-low reset clears sum and counts; table undefined until appended.
`default_nettype none

module discrete_distribution_sampler
  import dds_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  dds_in_if.sink    in_ch,
  dds_out_if.source out_ch
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_HOLD
  } state_t;

  state_t            state_r;
  logic              start_r;
  logic [VAL_W-1:0]  sum_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [WCNT_W-1:0] wcnt_r;
  logic [VAL_W-1:0]  u_r;

  logic [IDX_W-1:0]  res_idx_r;
  status_t           res_st_r;
  logic [VAL_W-1:0]  res_tot_r;
  logic [CNT_W-1:0]  res_ent_r;

  logic              out_vld_r;
  logic [IDX_W-1:0]  out_idx_r;
  status_t           out_st_r;
  logic [VAL_W-1:0]  out_tot_r;
  logic [CNT_W-1:0]  out_ent_r;

  state_t            state_nxt;
  logic              start_nxt;
  logic [VAL_W-1:0]  sum_nxt;
  logic [CNT_W-1:0]  cnt_nxt;
  logic [WCNT_W-1:0] wcnt_nxt;
  logic [VAL_W-1:0]  u_nxt;
  logic [IDX_W-1:0]  res_idx_nxt;
  status_t           res_st_nxt;
  logic [VAL_W-1:0]  res_tot_nxt;
  logic [CNT_W-1:0]  res_ent_nxt;
  logic              out_vld_nxt;
  logic [IDX_W-1:0]  out_idx_nxt;
  status_t           out_st_nxt;
  logic [VAL_W-1:0]  out_tot_nxt;
  logic [CNT_W-1:0]  out_ent_nxt;

  logic              accept;
  logic [VAL_W:0]    sum_ext;
  logic [VAL_W-1:0]  u_clamp;
  logic              append_ok;
  logic              wr_en;
  logic [CNT_W-1:0]  cnt_m1;
  tok_t              tap;
  logic              done;
  tok_t              tok [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] tok_vld;

  assign in_ch.ready = (state_r == S_IDLE) && rst_n;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    sum_ext   = {1'b0, sum_r} + {1'b0, in_ch.weight};
    u_clamp   = (in_ch.uniform > ONE) ? ONE : in_ch.uniform;
    append_ok = (wcnt_r < WCNT_W'(MAX_WEIGHTS)) && (in_ch.weight != '0)
                && (sum_ext <= {1'b0, ONE}) && (cnt_r < CNT_W'(TABLE_DEPTH));
    wr_en     = accept && (in_ch.opcode == OP_APPEND) && append_ok;
    cnt_m1    = cnt_r - CNT_W'(1);
    tap       = tok[cnt_m1[ADDR_W-1:0]];
    done      = (state_r == S_SEARCH) && tap.valid;
  end

  dds_chain u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start_r),
    .flush   (done),
    .wr_en   (wr_en),
    .wr_addr (cnt_r[ADDR_W-1:0]),
    .wr_cum  (sum_ext[VAL_W-1:0]),
    .wr_org  (wcnt_r[IDX_W-1:0]),
    .uni     (u_r),
    .tok_o   (tok)
  );

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_vld
    assign tok_vld[k] = tok[k].valid;
  end

  always_comb begin
    state_nxt   = state_r;
    start_nxt   = 1'b0;
    sum_nxt     = sum_r;
    cnt_nxt     = cnt_r;
    wcnt_nxt    = wcnt_r;
    u_nxt       = u_r;
    res_idx_nxt = res_idx_r;
    res_st_nxt  = res_st_r;
    res_tot_nxt = res_tot_r;
    res_ent_nxt = res_ent_r;
    out_vld_nxt = out_vld_r && !out_ch.ready;
    out_idx_nxt = out_idx_r;
    out_st_nxt  = out_st_r;
    out_tot_nxt = out_tot_r;
    out_ent_nxt = out_ent_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_idx_nxt = '0;
          res_st_nxt  = ST_OK;
          res_tot_nxt = sum_r;
          res_ent_nxt = cnt_r;
          state_nxt   = S_HOLD;
          case (in_ch.opcode)
            OP_CLEAR: begin
              sum_nxt     = '0;
              cnt_nxt     = '0;
              wcnt_nxt    = '0;
              res_tot_nxt = '0;
              res_ent_nxt = '0;
            end
            OP_APPEND: begin
              res_idx_nxt = wcnt_r[IDX_W-1:0];
              if (wcnt_r >= WCNT_W'(MAX_WEIGHTS)) begin
                res_st_nxt = ST_FULL;
              end else if (in_ch.weight == '0) begin
                res_st_nxt = ST_ZERO;
                wcnt_nxt   = wcnt_r + WCNT_W'(1);
              end else if (sum_ext > {1'b0, ONE}) begin
                res_st_nxt = ST_OVER;
              end else if (cnt_r >= CNT_W'(TABLE_DEPTH)) begin
                res_st_nxt = ST_FULL;
              end else begin
                sum_nxt     = sum_ext[VAL_W-1:0];
                cnt_nxt     = cnt_r + CNT_W'(1);
                wcnt_nxt    = wcnt_r + WCNT_W'(1);
                res_tot_nxt = sum_ext[VAL_W-1:0];
                res_ent_nxt = cnt_r + CNT_W'(1);
              end
            end
            OP_SAMPLE: begin
              u_nxt = u_clamp;
              if (u_clamp == '0) begin
                res_st_nxt = (sum_r < ONE) ? ST_SHORT : ST_OK;
              end else if (cnt_r == '0) begin
                res_st_nxt = ST_MISS;
              end else begin
                start_nxt = 1'b1;
                state_nxt = S_SEARCH;
              end
            end
            default: begin
              res_st_nxt = ST_OK;
            end
          endcase
        end
      end
      S_SEARCH: begin
        // Token reached the last stored entry: take its verdict.
        if (tap.valid) begin
          if (!tap.found) begin
            res_st_nxt = ST_MISS;
          end else begin
            res_idx_nxt = tap.idx;
            res_st_nxt  = (sum_r < ONE) ? ST_SHORT : ST_OK;
          end
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (!out_vld_r || out_ch.ready) begin
          out_vld_nxt = 1'b1;
          out_idx_nxt = res_idx_r;
          out_st_nxt  = res_st_r;
          out_tot_nxt = res_tot_r;
          out_ent_nxt = res_ent_r;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      start_r   <= 1'b0;
      out_vld_r <= 1'b0;
      sum_r     <= '0;
      cnt_r     <= '0;
      wcnt_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      start_r   <= start_nxt;
      out_vld_r <= out_vld_nxt;
      sum_r     <= sum_nxt;
      cnt_r     <= cnt_nxt;
      wcnt_r    <= wcnt_nxt;
    end
    u_r       <= u_nxt;
    res_idx_r <= res_idx_nxt;
    res_st_r  <= res_st_nxt;
    res_tot_r <= res_tot_nxt;
    res_ent_r <= res_ent_nxt;
    out_idx_r <= out_idx_nxt;
    out_st_r  <= out_st_nxt;
    out_tot_r <= out_tot_nxt;
    out_ent_r <= out_ent_nxt;
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.outcome_index = out_idx_r;
  assign out_ch.status        = out_st_r;
  assign out_ch.total         = out_tot_r;
  assign out_ch.entry_total   = out_ent_r;

  a_search_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SEARCH |-> cnt_r != '0)
    else $error("search running over an empty table");

  a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vld))
    else $error("more than one search token in the chain");

  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sum_r <= ONE && cnt_r <= CNT_W'(TABLE_DEPTH))
    else $error("running sum or entry count out of range");

  a_start_search: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> state_r == S_SEARCH && u_r != '0)
    else $error("token launched outside a search");

endmodule

`default_nettype wire
